@@ hw/rtl/crrb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crrb_pkg: shared types and constants for the command record/replay buffer
// Buffer geometry, function and opcode codes, controller state and the
// command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package crrb_pkg;

  localparam int BUFFER_DEPTH = 128;
  localparam int CW           = $clog2(BUFFER_DEPTH + 1);
  localparam int AW           = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int EXEC_W       = 8;
  localparam int EXEC_MAX     = 255;

  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_FLUSH  = 2'd1;
  localparam logic [1:0] FUNC_EMPTY  = 2'd2;
  localparam logic [1:0] FUNC_ZERO   = 2'd3;

  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_INK  = 3'd1;
  localparam logic [2:0] OP_JUMP = 3'd2;
  localparam logic [2:0] OP_LINE = 3'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
  } entry_t;

  typedef struct packed {
    logic record;
    logic clear_fill;
    logic zero_ctx;
    logic flush_start;
    logic issue;
    logic load_result;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic fill_zero;
    logic issue_last;
  } ctl_status_t;

  function automatic logic [EXEC_W-1:0] exec_sat(input logic [CW-1:0] n);
    if (32'(n) > EXEC_MAX) begin
      return EXEC_W'(EXEC_MAX);
    end
    return EXEC_W'(n);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/crrb_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crrb_in_if: request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface crrb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [2:0]         command_opcode;
  logic signed [31:0] arg_zero;
  logic signed [31:0] arg_one;
  logic signed [31:0] arg_two;
  logic signed [31:0] arg_three;

  modport source (
    output valid, func, command_opcode, arg_zero, arg_one, arg_two, arg_three,
    input  ready
  );
  modport sink (
    input  valid, func, command_opcode, arg_zero, arg_one, arg_two, arg_three,
    output ready
  );
endinterface
`default_nettype wire

@@ hw/rtl/crrb_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crrb_out_if: result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface crrb_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [7:0]         executed_count;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        ink_color;
  logic [31:0]        line_count;

  modport source (
    output valid, accepted, executed_count, pos_x, pos_y, ink_color, line_count,
    input  ready
  );
  modport sink (
    input  valid, accepted, executed_count, pos_x, pos_y, ink_color, line_count,
    output ready
  );
endinterface
`default_nettype wire

@@ hw/rtl/crrb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crrb_ctrl: operation sequencer
// Decodes accepted words and walks the buffer during a flush.
// ----------------------------------------------------------------------------
module crrb_ctrl import crrb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  crrb_in_if.sink          cmd,
  input  wire ctl_status_t status,
  output ctl_cmd_t         ctl
);

  state_t state;
  state_t state_next;
  logic   in_ready;

  assign cmd.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.valid && status.out_free && cmd.func == FUNC_FLUSH && !status.fill_zero) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (status.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = status.out_free;
        if (cmd.valid && status.out_free) begin
          case (cmd.func)
            FUNC_RECORD: begin
              ctl.record      = 1'b1;
              ctl.load_result = 1'b1;
            end
            FUNC_FLUSH: begin
              ctl.flush_start = 1'b1;
              ctl.load_result = status.fill_zero;
            end
            FUNC_EMPTY: begin
              ctl.clear_fill  = 1'b1;
              ctl.load_result = 1'b1;
            end
            FUNC_ZERO: begin
              ctl.zero_ctx    = 1'b1;
              ctl.load_result = 1'b1;
            end
            default: ctl = '0;
          endcase
        end
      end
      S_ISSUE: ctl.issue  = 1'b1;
      S_DRAIN: ctl.finish = 1'b1;
      default: ctl = '0;
    endcase
  end

  a_busy_out_free: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> status.out_free)
    else $error("result pending during flush");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.record, ctl.clear_fill, ctl.zero_ctx, ctl.flush_start,
              ctl.issue, ctl.finish}))
    else $error("conflicting commands");

endmodule
`default_nettype wire

@@ hw/rtl/crrb_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crrb_datapath: command store, drawing context and result register
// Holds the entry memory, fill count, replay index, context registers and
// the output word register.
// ----------------------------------------------------------------------------
module crrb_datapath import crrb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctl_cmd_t           ctl,
  output ctl_status_t             status,
  input  wire logic [2:0]         command_opcode,
  input  wire logic signed [31:0] arg_zero,
  input  wire logic signed [31:0] arg_one,
  input  wire logic signed [31:0] arg_two,
  input  wire logic signed [31:0] arg_three,
  crrb_out_if.source              rsp
);

  entry_t             mem [BUFFER_DEPTH];
  entry_t             rd_data;
  logic               rd_pend;
  logic [CW-1:0]      fill_count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      exec;
  logic [CW-1:0]      exec_next;
  logic               full;
  logic               applied;
  logic signed [31:0] cx, cx_next;
  logic signed [31:0] cy, cy_next;
  logic [31:0]        color, color_next;
  logic [31:0]        lines, lines_next;
  logic               out_valid;

  assign full              = (fill_count == CW'(BUFFER_DEPTH));
  assign status.out_free   = !out_valid || rsp.ready;
  assign status.fill_zero  = (fill_count == '0);
  assign status.issue_last = (CW'(idx + CW'(1)) == fill_count);

  always_ff @(posedge clk) begin
    if (ctl.record && !full) begin
      mem[fill_count[AW-1:0]] <= '{op: command_opcode, a0: arg_zero, a1: arg_one,
                                   a2: arg_two, a3: arg_three};
    end
    if (ctl.issue) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_comb begin
    cx_next    = cx;
    cy_next    = cy;
    color_next = color;
    lines_next = lines;
    applied    = 1'b0;
    if (ctl.zero_ctx) begin
      cx_next    = '0;
      cy_next    = '0;
      color_next = '0;
      lines_next = '0;
    end else if (rd_pend) begin
      case (rd_data.op)
        OP_NOP: applied = 1'b1;
        OP_INK: begin
          color_next = rd_data.a0;
          applied    = 1'b1;
        end
        OP_JUMP: begin
          cx_next = rd_data.a0;
          cy_next = rd_data.a1;
          applied = 1'b1;
        end
        OP_LINE: begin
          lines_next = lines + 32'd1;
          cx_next    = rd_data.a2;
          cy_next    = rd_data.a3;
          applied    = 1'b1;
        end
        default: applied = 1'b0;
      endcase
    end
  end

  assign exec_next = ctl.flush_start ? '0 : CW'(exec + CW'(applied));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      idx        <= '0;
      exec       <= '0;
      rd_pend    <= 1'b0;
      cx         <= '0;
      cy         <= '0;
      color      <= '0;
      lines      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.clear_fill) begin
        fill_count <= '0;
      end else if (ctl.record && !full) begin
        fill_count <= CW'(fill_count + CW'(1));
      end
      if (ctl.flush_start) begin
        idx <= '0;
      end else if (ctl.issue) begin
        idx <= CW'(idx + CW'(1));
      end
      exec    <= exec_next;
      rd_pend <= ctl.issue;
      cx      <= cx_next;
      cy      <= cy_next;
      color   <= color_next;
      lines   <= lines_next;
      if (ctl.load_result || ctl.finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_result || ctl.finish) begin
      rsp.accepted       <= ctl.record && !full;
      rsp.executed_count <= ctl.finish ? exec_sat(exec_next) : '0;
      rsp.pos_x          <= cx_next;
      rsp.pos_y          <= cy_next;
      rsp.ink_color      <= color_next;
      rsp.line_count     <= lines_next;
    end
  end

  assign rsp.valid = out_valid;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(BUFFER_DEPTH))
    else $error("fill count beyond depth");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.issue |-> (idx < fill_count))
    else $error("read beyond filled entries");

  a_pend_after_issue: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(ctl.issue))
    else $error("read data applied without a read");

  a_rise_after_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.load_result || ctl.finish))
    else $error("result word without a load");

endmodule
`default_nettype wire

@@ hw/rtl/command_record_replay_buffer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// command_record_replay_buffer: record and replay of drawing commands
// Stores up to BUFFER_DEPTH commands and replays them against a cursor,
// pen color and line tally.
//
// Channels: cmd takes one operation word (record, flush, empty, zero
// context); rsp returns exactly one result word per operation.
// Record, empty and zero context: result registered in the cycle after
// acceptance; a new word is taken every cycle while rsp is drained.
// Flush of N stored entries: the sequencer reads the entry memory one entry
// per cycle, then the drain state loads the result word (for an empty
// buffer, in the cycle after acceptance); cmd stays not ready meanwhile.
// The result sits in an output register; cmd is taken in a cycle when that
// register is empty or being read. If rsp stalls, cmd stalls with it.
// Reset: fill count, context, sequencer and result valid clear
// synchronously; stored entries keep their contents and are never read
// before being written.
// ----------------------------------------------------------------------------
module command_record_replay_buffer import crrb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  crrb_in_if.sink   cmd,
  crrb_out_if.source rsp
);

  ctl_cmd_t    ctl;
  ctl_status_t status;

  crrb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .ctl    (ctl)
  );

  crrb_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .status         (status),
    .command_opcode (cmd.command_opcode),
    .arg_zero       (cmd.arg_zero),
    .arg_one        (cmd.arg_one),
    .arg_two        (cmd.arg_two),
    .arg_three      (cmd.arg_three),
    .rsp            (rsp)
  );

endmodule
`default_nettype wire

@@ verif/tb_command_record_replay_buffer.sv @@
// ----------------------------------------------------------------------------
// tb_command_record_replay_buffer: self-checking bench for the record/replay
// buffer
// Drives operation words on the cmd channel and predicts each status word
// with a local copy of the buffer and drawing context. It covers opcode and
// operand extremes, a full buffer, and random traffic under several
// sender-idle and receiver-stall mixes. Every word on rsp is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_command_record_replay_buffer;
  import crrb_pkg::*;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  executed_count;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] ink_color;
    logic [31:0] line_count;
  } status_t;

  logic clk;
  logic rst;

  crrb_in_if  cmd_if ();
  crrb_out_if rsp_if ();

  command_record_replay_buffer i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if.sink),
    .rsp (rsp_if.source)
  );

  entry_t      stored [BUFFER_DEPTH];
  int unsigned stored_fill;
  logic [31:0] model_x;
  logic [31:0] model_y;
  logic [31:0] model_color;
  logic [31:0] model_lines;

  status_t     expected_status [$];
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic status_t predict_status(input logic [1:0] func, input entry_t word);
    status_t     s;
    int unsigned n;
    s = '0;
    n = 0;
    case (func)
      FUNC_RECORD: begin
        if (stored_fill < BUFFER_DEPTH) begin
          stored[stored_fill] = word;
          stored_fill++;
          s.accepted = 1'b1;
        end
      end
      FUNC_FLUSH: begin
        for (int i = 0; i < stored_fill; i++) begin
          case (stored[i].op)
            OP_NOP: n++;
            OP_INK: begin
              model_color = stored[i].a0;
              n++;
            end
            OP_JUMP: begin
              model_x = stored[i].a0;
              model_y = stored[i].a1;
              n++;
            end
            OP_LINE: begin
              model_lines = model_lines + 32'd1;
              model_x = stored[i].a2;
              model_y = stored[i].a3;
              n++;
            end
            default: ;
          endcase
        end
        s.executed_count = (n > EXEC_MAX) ? EXEC_W'(EXEC_MAX) : EXEC_W'(n);
      end
      FUNC_EMPTY: stored_fill = 0;
      FUNC_ZERO: begin
        model_x = '0;
        model_y = '0;
        model_color = '0;
        model_lines = '0;
      end
      default: ;
    endcase
    s.pos_x = model_x;
    s.pos_y = model_y;
    s.ink_color = model_color;
    s.line_count = model_lines;
    return s;
  endfunction

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected word expected none actual cx %h cy %h color %h lines %h",
                 $time, rsp_if.pos_x, rsp_if.pos_y, rsp_if.ink_color,
                 rsp_if.line_count);
        mismatch_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(rsp_if.accepted));
        check_field("executed_count", 32'(want.executed_count), 32'(rsp_if.executed_count));
        check_field("pos_x", want.pos_x, rsp_if.pos_x);
        check_field("pos_y", want.pos_y, rsp_if.pos_y);
        check_field("ink_color", want.ink_color, rsp_if.ink_color);
        check_field("line_count", want.line_count, rsp_if.line_count);
      end
    end
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic issue_operation(input logic [1:0] func, input logic [2:0] op,
                                 input logic [31:0] a0, input logic [31:0] a1,
                                 input logic [31:0] a2, input logic [31:0] a3);
    entry_t word;
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid          <= 1'b1;
    cmd_if.func           <= func;
    cmd_if.command_opcode <= op;
    cmd_if.arg_zero       <= a0;
    cmd_if.arg_one        <= a1;
    cmd_if.arg_two        <= a2;
    cmd_if.arg_three      <= a3;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    word.op = op;
    word.a0 = a0;
    word.a1 = a1;
    word.a2 = a2;
    word.a3 = a3;
    expected_status.push_back(predict_status(func, word));
  endtask

  task automatic issue_random(input logic [1:0] func);
    logic [2:0] op;
    op = ($urandom_range(4) == 0) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
    issue_operation(func, op, pick_arg(), pick_arg(), pick_arg(), pick_arg());
  endtask

  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic test_opcodes_and_extremes();
    logic [31:0] ext [4];
    ext[0] = 32'h8000_0000;
    ext[1] = 32'h7fff_ffff;
    ext[2] = 32'h0000_0000;
    ext[3] = 32'hffff_ffff;
    issue_operation(FUNC_ZERO, OP_NOP, ext[3], ext[3], ext[3], ext[3]);
    issue_operation(FUNC_FLUSH, OP_LINE, ext[1], ext[1], ext[1], ext[1]);
    for (int i = 0; i < 8; i++) begin
      issue_operation(FUNC_RECORD, 3'(i), ext[i % 4], ext[(i + 1) % 4],
                      ext[(i + 2) % 4], ext[(i + 3) % 4]);
    end
    issue_operation(FUNC_FLUSH, OP_NOP, ext[0], ext[0], ext[0], ext[0]);
    issue_operation(FUNC_RECORD, OP_LINE, ext[1], ext[0], ext[0], ext[1]);
    issue_operation(FUNC_RECORD, OP_INK, ext[3], ext[2], ext[2], ext[2]);
    issue_operation(FUNC_FLUSH, OP_INK, ext[2], ext[2], ext[2], ext[2]);
    issue_operation(FUNC_FLUSH, OP_JUMP, ext[3], ext[0], ext[1], ext[2]);
    issue_operation(FUNC_EMPTY, OP_LINE, ext[0], ext[1], ext[2], ext[3]);
    issue_operation(FUNC_FLUSH, OP_NOP, ext[1], ext[1], ext[1], ext[1]);
    issue_operation(FUNC_ZERO, OP_JUMP, ext[0], ext[0], ext[0], ext[0]);
    issue_operation(FUNC_RECORD, OP_JUMP, ext[0], ext[1], ext[3], ext[3]);
    issue_operation(FUNC_FLUSH, OP_NOP, ext[2], ext[2], ext[2], ext[2]);
    drain_results();
  endtask

  task automatic test_full_buffer();
    issue_operation(FUNC_EMPTY, OP_NOP, '0, '0, '0, '0);
    repeat (BUFFER_DEPTH + 3) issue_random(FUNC_RECORD);
    issue_random(FUNC_FLUSH);
    issue_random(FUNC_ZERO);
    issue_random(FUNC_FLUSH);
    issue_random(FUNC_EMPTY);
    issue_random(FUNC_RECORD);
    issue_random(FUNC_FLUSH);
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned r;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 70) begin
        issue_random(FUNC_RECORD);
      end else if (r < 85) begin
        issue_random(FUNC_FLUSH);
      end else if (r < 93) begin
        issue_random(FUNC_EMPTY);
      end else begin
        issue_random(FUNC_ZERO);
      end
    end
    drain_results();
  endtask

  initial begin
    clk                   = 1'b0;
    rst                   = 1'b1;
    cmd_if.valid          = 1'b0;
    cmd_if.func           = FUNC_RECORD;
    cmd_if.command_opcode = OP_NOP;
    cmd_if.arg_zero       = '0;
    cmd_if.arg_one        = '0;
    cmd_if.arg_two        = '0;
    cmd_if.arg_three      = '0;
    rsp_if.ready          = 1'b0;
    stored_fill           = 0;
    model_x               = '0;
    model_y               = '0;
    model_color           = '0;
    model_lines           = '0;
    mismatch_count        = 0;
    sender_idle_pct       = 0;
    recv_stall_pct        = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_opcodes_and_extremes();
    test_full_buffer();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 74, 0);
    test_random_traffic(150, 0, 74);
    test_random_traffic(150, 14, 14);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_command_record_replay_buffer passed");
    end else begin
      $display("tb_command_record_replay_buffer failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_command_record_replay_buffer failed");
    $finish;
  end

endmodule
